// ===== hdl/mouse_packet_cursor_tracker_unit_assert.svh =====
// Assertion macros for the mouse packet cursor tracker checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_UNIT_ASSERT_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpct assertion failed");

// Next-cycle implication, disabled during reset.
`define MPCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpct assertion failed");

// State directly after a reset cycle.
`define MPCT_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("mpct reset assertion failed");

`endif

// ===== hdl/mpct_pkg.sv =====
// Shared types, constants and helper functions for the cursor tracker.
// No dependencies.
package mpct_pkg;

  typedef logic [8:0] pos_t;
  typedef logic [2:0] btn_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_UPDATE_ENABLE = 2'd0;
  localparam cfg_idx_t CFG_X_LIMIT       = 2'd1;
  localparam cfg_idx_t CFG_Y_LIMIT       = 2'd2;

  localparam pos_t X_LIMIT_RST = 9'd319;
  localparam pos_t Y_LIMIT_RST = 9'd199;
  localparam pos_t POS_X_RST   = 9'd160;
  localparam pos_t POS_Y_RST   = 9'd100;

  typedef struct packed {
    logic update_enable;
    pos_t x_limit;
    pos_t y_limit;
  } cfg_t;

  typedef struct packed {
    logic  aux_ready;
    byte_t data_byte;
  } item_t;

  typedef struct packed {
    pos_t cursor_x;
    pos_t cursor_y;
    btn_t buttons;
    logic packet_done;
  } result_t;

  // Signed byte divided by two, truncating toward zero.
  function automatic logic signed [6:0] half_delta(input byte_t b);
    logic signed [8:0] v;
    v = $signed({b[7], b}) + $signed({8'd0, b[7]});
    return v[7:1];
  endfunction

  function automatic pos_t clamp_pos(input logic signed [10:0] v, input pos_t limit);
    pos_t res;
    if (v < 0) begin
      res = '0;
    end else if (v[9:0] > {1'b0, limit}) begin
      res = limit;
    end else begin
      res = v[8:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/mpct_cfg_regs.sv =====
// Configuration registers of the cursor tracker.
// Depends on mpct_pkg.
module mpct_cfg_regs
  import mpct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  pos_t     cfg_wdata,
  output cfg_t     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_enable <= 1'b0;
      cfg_r.x_limit       <= X_LIMIT_RST;
      cfg_r.y_limit       <= Y_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPDATE_ENABLE: cfg_r.update_enable <= cfg_wdata[0];
        CFG_X_LIMIT:       cfg_r.x_limit       <= cfg_wdata;
        CFG_Y_LIMIT:       cfg_r.y_limit       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mpct_in_stage.sv =====
// Input register stage of the cursor tracker.
// Depends on mpct_pkg.
module mpct_in_stage
  import mpct_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_aux_ready,
  input  byte_t in_data_byte,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  s1_valid_r;
  item_t s1_item_r;

  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.aux_ready <= in_aux_ready;
      s1_item_r.data_byte <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== hdl/mpct_track.sv =====
// Packet assembly and cursor state update of the cursor tracker.
// Depends on mpct_pkg.
module mpct_track
  import mpct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res_nxt
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

  phase_t phase_r, phase_nxt;
  byte_t  first_r, first_nxt;
  byte_t  second_r, second_nxt;
  pos_t   pos_x_r, pos_x_nxt;
  pos_t   pos_y_r, pos_y_nxt;
  btn_t   btn_r, btn_nxt;
  logic   done;
  logic signed [10:0] nx;
  logic signed [10:0] ny;

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    btn_nxt    = btn_r;
    done       = 1'b0;
    nx = $signed({2'b00, pos_x_r}) + 11'(half_delta(second_r));
    ny = $signed({2'b00, pos_y_r}) - 11'(half_delta(item.data_byte));
    if (item.aux_ready) begin
      unique case (phase_r)
        PH_FIRST: begin
          first_nxt = item.data_byte;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          second_nxt = item.data_byte;
          phase_nxt  = PH_THIRD;
        end
        PH_THIRD: begin
          phase_nxt = PH_FIRST;
          done      = 1'b1;
          if (cfg.update_enable) begin
            btn_nxt   = first_r[2:0];
            pos_x_nxt = clamp_pos(nx, cfg.x_limit);
            pos_y_nxt = clamp_pos(ny, cfg.y_limit);
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
      btn_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      btn_r   <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign res_nxt.cursor_x    = pos_x_nxt;
  assign res_nxt.cursor_y    = pos_y_nxt;
  assign res_nxt.buttons     = btn_nxt;
  assign res_nxt.packet_done = done;

endmodule

// ===== hdl/mouse_packet_cursor_tracker_unit.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_aux_ready, in_data_byte
// out      out_valid / out_ready  out_cursor_x, out_cursor_y, out_buttons, out_packet_done
// cfg      cfg_we                 cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_ready stays high; a byte's result reaches the
// outputs through the input register, then the state update and result register.
// Reset (rst_n low, synchronous) empties both registers, restores position 160/100,
// limits 319/199, buttons 0 and updates disabled.
// A stalled result holds in the output register; the input register still takes
// one more transaction, then in_ready drops until out_ready returns.
// Depends on mpct_pkg, mpct_cfg_regs, mpct_in_stage, mpct_track.
module mouse_packet_cursor_tracker_unit
  import mpct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_aux_ready,
  input  byte_t    in_data_byte,
  output logic     out_valid,
  input  logic     out_ready,
  output pos_t     out_cursor_x,
  output pos_t     out_cursor_y,
  output btn_t     out_buttons,
  output logic     out_packet_done,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  pos_t     cfg_wdata
);

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;

  assign advance = s1_valid && (!out_valid_r || out_ready);

  mpct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpct_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_aux_ready (in_aux_ready),
    .in_data_byte (in_data_byte),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  mpct_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_x    = res_r.cursor_x;
  assign out_cursor_y    = res_r.cursor_y;
  assign out_buttons     = res_r.buttons;
  assign out_packet_done = res_r.packet_done;

endmodule

// ===== hdl/mpct_checker.sv =====
// Port-level checker for the cursor tracker, bound to the top level.
// Depends on mpct_pkg and mouse_packet_cursor_tracker_unit_assert.svh.
`include "mouse_packet_cursor_tracker_unit_assert.svh"

module mpct_checker
  import mpct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pos_t     out_cursor_x,
  input pos_t     out_cursor_y,
  input btn_t     out_buttons,
  input logic     out_packet_done
);

  `MPCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cursor_x) && $stable(out_cursor_y) && $stable(out_buttons) && $stable(out_packet_done))
  `MPCT_ASSERT_NXT(a_done_spacing, out_valid && out_ready && out_packet_done, !(out_valid && out_packet_done))
  `MPCT_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
  `MPCT_ASSERT_RST(a_reset_empty, !out_valid)

endmodule

bind mouse_packet_cursor_tracker_unit mpct_checker u_mpct_checker (.*);

// ===== test/tb_mouse_packet_cursor_tracker_unit.sv =====
// Testbench for mouse_packet_cursor_tracker_unit: random mouse bytes with stalls on both sides,
// checked against a cycle-free cursor tracking predictor.
// Depends on mpct_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_mouse_packet_cursor_tracker_unit;
  import mpct_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  logic     in_aux_ready = 1'b0;
  byte_t    in_data_byte = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pos_t     out_cursor_x;
  pos_t     out_cursor_y;
  btn_t     out_buttons;
  logic     out_packet_done;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_UPDATE_ENABLE;
  pos_t     cfg_wdata = '0;

  mouse_packet_cursor_tracker_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_aux_ready    (in_aux_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_buttons     (out_buttons),
    .out_packet_done (out_packet_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Tracker copy used for prediction.
  logic    upd_en = 1'b0;
  pos_t    lim_x = 9'd319;
  pos_t    lim_y = 9'd199;
  int      phase_idx = 0;
  byte_t   pkt_b0 = '0;
  byte_t   pkt_b1 = '0;
  pos_t    cur_x = 9'd160;
  pos_t    cur_y = 9'd100;
  btn_t    cur_btn = '0;

  item_t   byte_q[$];
  result_t cursor_q[$];

  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;

  function automatic int half_toward_zero(byte_t b);
    int v;
    v = $signed(b);
    return v / 2;
  endfunction

  function automatic pos_t clip_to_limit(int v, pos_t lim);
    if (v < 0) begin
      return '0;
    end else if (v > int'(lim)) begin
      return lim;
    end
    return pos_t'(v);
  endfunction

  function automatic result_t track_cursor(item_t it);
    result_t r;
    r.packet_done = 1'b0;
    if (it.aux_ready) begin
      if (phase_idx == 0) begin
        pkt_b0 = it.data_byte;
        phase_idx = 1;
      end else if (phase_idx == 1) begin
        pkt_b1 = it.data_byte;
        phase_idx = 2;
      end else begin
        phase_idx = 0;
        r.packet_done = 1'b1;
        if (upd_en) begin
          cur_btn = pkt_b0[2:0];
          cur_x = clip_to_limit(int'(cur_x) + half_toward_zero(pkt_b1), lim_x);
          cur_y = clip_to_limit(int'(cur_y) - half_toward_zero(it.data_byte), lim_y);
        end
      end
    end
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    r.buttons = cur_btn;
    return r;
  endfunction

  // Driver: present queued transactions, hold while stalled.
  always @(posedge clk) begin
    item_t cur;
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.aux_ready = in_aux_ready;
        cur.data_byte = in_data_byte;
        cursor_q.push_back(track_cursor(cur));
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_aux_ready <= nxt.aux_ready;
        in_data_byte <= nxt.data_byte;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure plus requested long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (cursor_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("unexpected result: x=%0d y=%0d btn=%0d done=%0d",
                   out_cursor_x, out_cursor_y, out_buttons, out_packet_done);
        end
      end else begin
        exp_r = cursor_q.pop_front();
        if (exp_r.cursor_x !== out_cursor_x || exp_r.cursor_y !== out_cursor_y ||
            exp_r.buttons !== out_buttons || exp_r.packet_done !== out_packet_done) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("mismatch: expected x=%0d y=%0d btn=%0d done=%0d, got x=%0d y=%0d btn=%0d done=%0d",
                     exp_r.cursor_x, exp_r.cursor_y, exp_r.buttons, exp_r.packet_done,
                     out_cursor_x, out_cursor_y, out_buttons, out_packet_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_byte(logic aux, byte_t data);
    item_t it;
    it.aux_ready = aux;
    it.data_byte = data;
    byte_q.push_back(it);
  endtask

  // Check between edges so that the driver and monitor updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (byte_q.size() != 0 || in_valid || cursor_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, pos_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_UPDATE_ENABLE: upd_en = value[0];
      CFG_X_LIMIT:       lim_x = value;
      CFG_Y_LIMIT:       lim_y = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic byte_t pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_random(int count, int send_pct, int recv_pct, bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      push_byte($urandom_range(0, 99) < 85, pick_data());
    end
    if (with_hold) begin
      hold_requests = hold_requests + 1;
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Updates disabled after reset: packet is consumed without effect.
    push_byte(1'b0, 8'hAA);
    push_byte(1'b1, 8'h07);
    push_byte(1'b1, 8'h7F);
    push_byte(1'b1, 8'h80);
    wait_drained();

    write_reg(CFG_UPDATE_ENABLE, 9'd1);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b1, 8'h7F);
    push_byte(1'b0, 8'h55);
    push_byte(1'b1, 8'h80);
    push_byte(1'b1, 8'h00);
    push_byte(1'b1, 8'h80);
    push_byte(1'b1, 8'h7F);
    push_byte(1'b1, 8'h05);
    push_byte(1'b1, 8'h01);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b1, 8'h02);
    push_byte(1'b1, 8'hFF);
    push_byte(1'b1, 8'h01);
    wait_drained();

    // Lowered limits: position stays out of range until the next packet.
    write_reg(CFG_X_LIMIT, 9'd10);
    write_reg(CFG_Y_LIMIT, 9'd5);
    push_byte(1'b0, 8'h00);
    push_byte(1'b1, 8'h01);
    push_byte(1'b1, 8'h00);
    push_byte(1'b1, 8'h00);
    push_byte(1'b1, 8'hF8);
    push_byte(1'b1, 8'h80);
    push_byte(1'b1, 8'h7F);
    wait_drained();

    write_reg(CFG_X_LIMIT, 9'd319);
    write_reg(CFG_Y_LIMIT, 9'd199);
    run_random(400, 7, 52, 1'b0);

    write_reg(CFG_X_LIMIT, 9'd511);
    write_reg(CFG_Y_LIMIT, 9'd511);
    run_random(300, 52, 7, 1'b1);

    write_reg(CFG_X_LIMIT, 9'd0);
    write_reg(CFG_Y_LIMIT, 9'd0);
    write_reg(CFG_UPDATE_ENABLE, 9'h1FF);
    run_random(150, 0, 0, 1'b0);

    write_reg(CFG_UPDATE_ENABLE, 9'h1FE);
    run_random(60, 0, 0, 1'b0);

    write_reg(CFG_UPDATE_ENABLE, pos_t'($urandom_range(0, 511)));
    write_reg(CFG_X_LIMIT, pos_t'($urandom_range(0, 511)));
    write_reg(CFG_Y_LIMIT, pos_t'($urandom_range(0, 511)));
    run_random(200, 0, 0, 1'b0);

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && cursor_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mpct_pkg.sv
hdl/mpct_cfg_regs.sv
hdl/mpct_in_stage.sv
hdl/mpct_track.sv
hdl/mouse_packet_cursor_tracker_unit.sv
hdl/mpct_checker.sv
test/tb_mouse_packet_cursor_tracker_unit.sv
